@@ src/kdeg_pkg.sv @@
// ----------------------------------------------------------------------------
// kdeg_pkg - shared types for the keypad debounce event generator
// Sequencer states, control groups between the sequencer and its units,
// and the fixed widths of the stream fields.
// ----------------------------------------------------------------------------
package kdeg_pkg;

    // fixed field widths
    localparam int SCAN_W      = 12;
    localparam int KEY_INDEX_W = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_EMIT   = 4'b1000
    } seq_state_t;

    // control into the history ring and its accumulator
    typedef struct packed {
        logic write;    // store scan word, restart accumulation
        logic step;     // fold one slot into the accumulators
    } hist_ctrl_t;

    // control into the event generator
    typedef struct packed {
        logic load;     // latch the change mask
        logic run;      // walk the keys
    } evt_ctrl_t;

endpackage

@@ src/kdeg_history.sv @@
// ----------------------------------------------------------------------------
// kdeg_history - scan history ring with a shared fold unit
// Holds HISTORY_DEPTH scan words. After a write, one slot per step is folded
// into an any-low and an all-high mask.
// ----------------------------------------------------------------------------
module kdeg_history #(
    parameter int HISTORY_DEPTH = 5,
    parameter int KEY_COUNT     = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kdeg_pkg::hist_ctrl_t     ctrl,
    input  logic [KEY_COUNT-1:0]     scan,
    output logic [KEY_COUNT-1:0]     any_low,
    output logic [KEY_COUNT-1:0]     all_high,
    output logic                     fold_last
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    logic [KEY_COUNT-1:0] hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]    wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [KEY_COUNT-1:0] any_low_reg, any_low_next;
    logic [KEY_COUNT-1:0] all_high_reg, all_high_next;
    logic [KEY_COUNT-1:0] rd_word;

    assign rd_word   = hist_reg[rd_slot_reg];
    assign fold_last = (rd_slot_reg == LAST_SLOT);
    assign any_low   = any_low_reg;
    assign all_high  = all_high_reg;

    // pointers and fold unit
    always_comb begin
        wr_slot_next  = wr_slot_reg;
        rd_slot_next  = rd_slot_reg;
        any_low_next  = any_low_reg;
        all_high_next = all_high_reg;
        if (ctrl.write) begin
            wr_slot_next  = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
            rd_slot_next  = '0;
            any_low_next  = '0;
            all_high_next = '1;
        end else if (ctrl.step) begin
            rd_slot_next  = fold_last ? '0 : rd_slot_reg + 1'b1;
            any_low_next  = any_low_reg | ~rd_word;
            all_high_next = all_high_reg & rd_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '1;
            end
        end else begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            if (ctrl.write) begin
                hist_reg[wr_slot_reg] <= scan;
            end
        end
    end

    // accumulators are payload
    always_ff @(posedge aclk) begin
        any_low_reg  <= any_low_next;
        all_high_reg <= all_high_next;
    end

endmodule

@@ src/kdeg_event_gen.sv @@
// ----------------------------------------------------------------------------
// kdeg_event_gen - stable key mask and serial event output
// Latches the keys whose stable state changes, then walks the keys one per
// cycle while the output register is free, placing one event at a time in it.
// ----------------------------------------------------------------------------
module kdeg_event_gen #(
    parameter int KEY_COUNT = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kdeg_pkg::evt_ctrl_t                 ctrl,
    input  logic [KEY_COUNT-1:0]                any_low,
    input  logic [KEY_COUNT-1:0]                all_high,
    output logic                                pending_empty,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kdeg_pkg::KEY_INDEX_W-1:0]    key_index,
    output logic                                pressed,
    output logic                                last
);

    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [KEY_COUNT-1:0]               stable_reg, stable_next;
    logic [KEY_COUNT-1:0]               pending_reg, pending_next;
    logic [KEY_W-1:0]                   key_reg, key_next;
    logic                               valid_reg, valid_next;
    logic [kdeg_pkg::KEY_INDEX_W-1:0]   index_reg, index_next;
    logic                               pressed_reg, pressed_next;
    logic                               last_reg, last_next;
    logic [KEY_COUNT-1:0]               key_bit;
    logic [KEY_COUNT-1:0]               rest;
    logic                               slot_free;

    assign key_bit       = KEY_COUNT'(1) << key_reg;
    assign rest          = pending_reg & ~key_bit;
    assign slot_free     = !valid_reg || m_tready;
    assign pending_empty = (pending_reg == '0);

    // key walk and output register
    always_comb begin
        stable_next  = stable_reg;
        pending_next = pending_reg;
        key_next     = key_reg;
        valid_next   = valid_reg && !m_tready;
        index_next   = index_reg;
        pressed_next = pressed_reg;
        last_next    = last_reg;
        if (ctrl.load) begin
            pending_next = (~stable_reg & any_low) | (stable_reg & all_high);
            key_next     = '0;
        end else if (ctrl.run && slot_free && !pending_empty) begin
            key_next = key_reg + 1'b1;
            if (pending_reg[key_reg]) begin
                // a changing key toggles its stable state
                stable_next[key_reg] = ~stable_reg[key_reg];
                pending_next         = rest;
                valid_next           = 1'b1;
                index_next           = kdeg_pkg::KEY_INDEX_W'(key_reg);
                pressed_next         = ~stable_reg[key_reg];
                last_next            = (rest == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg  <= '0;
            pending_reg <= '0;
            key_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            stable_reg  <= stable_next;
            pending_reg <= pending_next;
            key_reg     <= key_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg   <= index_next;
        pressed_reg <= pressed_next;
        last_reg    <= last_next;
    end

    assign m_tvalid  = valid_reg;
    assign key_index = index_reg;
    assign pressed   = pressed_reg;
    assign last      = last_reg;

endmodule

@@ src/keypad_debounce_event_generator.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_event_generator - key matrix debounce and event stream
// Stores each scan word in a history ring, folds the ring into down/up masks
// and emits one press or release event per key whose stable state changes.
//
//   channel  dir  tdata bits                      side bits
//   s_       in   [11:0] scan_bits                -
//   m_       out  [3:0] key_index, [4] pressed    tlast = last
//
// Each scan is accepted, folded one slot per step through the shared fold unit
// across all HISTORY_DEPTH slots, loaded as a change mask and then walked key
// by key up to the last changing key, until the change mask is seen empty.
// s_tready is high only while the sequencer is idle.
// A stalled m_ side holds the key walk; the next scan can still be taken while
// the final event waits in the output register.
// Reset: history all released, slot 0, no key down, output empty.
// ----------------------------------------------------------------------------
module keypad_debounce_event_generator #(
    parameter int HISTORY_DEPTH = 5,
    parameter int ROW_COUNT     = 3,
    parameter int COLUMN_COUNT  = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kdeg_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] scan_bits
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kdeg_pkg::M_TDATA_W-1:0]    m_tdata,   // [3:0] key_index, [4] pressed
    output logic                              m_tlast    // last
);

    localparam int KEY_COUNT = ROW_COUNT * COLUMN_COUNT;

    typedef logic [KEY_COUNT-1:0] keys_t;

    kdeg_pkg::seq_state_t state_reg, state_next;
    kdeg_pkg::hist_ctrl_t hist_ctrl;
    kdeg_pkg::evt_ctrl_t  evt_ctrl;

    keys_t                              scan_keys;
    keys_t                              any_low;
    keys_t                              all_high;
    logic                               fold_last;
    logic                               pending_empty;
    logic [kdeg_pkg::KEY_INDEX_W-1:0]   key_index;
    logic                               pressed;
    logic                               s_accept;

    assign s_tready  = (state_reg == kdeg_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign scan_keys = keys_t'(s_tdata[kdeg_pkg::SCAN_W-1:0]);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        hist_ctrl.write = 1'b0;
        hist_ctrl.step  = 1'b0;
        evt_ctrl.load   = 1'b0;
        evt_ctrl.run    = 1'b0;
        unique case (state_reg)
            kdeg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    hist_ctrl.write = 1'b1;
                    state_next      = kdeg_pkg::ST_REDUCE;
                end
            end
            kdeg_pkg::ST_REDUCE: begin
                hist_ctrl.step = 1'b1;
                if (fold_last) begin
                    state_next = kdeg_pkg::ST_LOAD;
                end
            end
            kdeg_pkg::ST_LOAD: begin
                evt_ctrl.load = 1'b1;
                state_next    = kdeg_pkg::ST_EMIT;
            end
            kdeg_pkg::ST_EMIT: begin
                evt_ctrl.run = 1'b1;
                if (pending_empty) begin
                    state_next = kdeg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kdeg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kdeg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    kdeg_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .KEY_COUNT     (KEY_COUNT)
    ) u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (hist_ctrl),
        .scan      (scan_keys),
        .any_low   (any_low),
        .all_high  (all_high),
        .fold_last (fold_last)
    );

    kdeg_event_gen #(
        .KEY_COUNT (KEY_COUNT)
    ) u_event_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (evt_ctrl),
        .any_low       (any_low),
        .all_high      (all_high),
        .pending_empty (pending_empty),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .key_index     (key_index),
        .pressed       (pressed),
        .last          (m_tlast)
    );

    // pack result fields, zero fill to the byte
    assign m_tdata = {{(kdeg_pkg::M_TDATA_W - kdeg_pkg::KEY_INDEX_W - 1){1'b0}},
                      pressed, key_index};

endmodule
